// File: design/acked_delivery_retry_tracker_assert.svh
// Assertion macros for the acked delivery retry tracker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ACKED_DELIVERY_RETRY_TRACKER_ASSERT_SVH
`define ACKED_DELIVERY_RETRY_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADRT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adrt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ADRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adrt: next-cycle check failed");

`endif

// File: design/adrt_pkg.sv
// Shared types and constants for the acked delivery retry tracker.
// No dependencies; every design module imports this package.
package adrt_pkg;

    localparam int unsigned NUM_COUNTERS      = 8;
    localparam int unsigned MAX_ATTEMPT_LIMIT = 8;
    localparam logic [15:0] RETRY_RESET_MS    = 16'd1000;

    // Positions in the event counter bank.
    localparam int unsigned CNT_STARTS    = 0;
    localparam int unsigned CNT_SENDS     = 1;
    localparam int unsigned CNT_RETRIES   = 2;
    localparam int unsigned CNT_DELIVERED = 3;
    localparam int unsigned CNT_EXPIRED   = 4;
    localparam int unsigned CNT_CANCELLED = 5;
    localparam int unsigned CNT_FAILED    = 6;
    localparam int unsigned CNT_INVALID   = 7;

    typedef enum logic [1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_POLL   = 2'd1,
        KIND_ACK    = 2'd2,
        KIND_CANCEL = 2'd3
    } item_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT      = 3'd1,
        PH_EXPIRED   = 3'd2,
        PH_FAILED    = 3'd3,
        PH_DELIVERED = 3'd4,
        PH_CANCELLED = 3'd5
    } plan_phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ARG     = 3'd1,
        ST_STATE   = 3'd2,
        ST_AUTH    = 3'd3,
        ST_EXPIRED = 3'd4
    } status_code_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_SEND      = 3'd1,
        EV_RETRY     = 3'd2,
        EV_EXPIRED   = 3'd3,
        EV_FAILED    = 3'd4,
        EV_DELIVERED = 3'd5,
        EV_CANCELLED = 3'd6
    } event_code_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [15:0] seq;
        logic [7:0]  attempt_limit;
        logic [63:0] now_ms;
        logic [63:0] deadline;
        logic        authorized;
    } in_item_t;

    // Outcome of one event as decided by the plan logic.
    typedef struct packed {
        status_code_t              status;
        event_code_t               event_res;
        plan_phase_t               plan_state;
        logic [7:0]                attempts_made;
        logic [NUM_COUNTERS-1:0]   bump;
    } plan_dec_t;

    typedef logic [NUM_COUNTERS-1:0][31:0] counter_bank_t;

endpackage

// File: design/acked_delivery_retry_tracker.sv
// Top level of the acked delivery retry tracker: stream ports, input and result registers.
// Depends on adrt_pkg, adrt_plan, adrt_counters and the assertion macro header.
//
//  Channel | Direction | Handshake                      | Payload
//  s_axis  | in        | s_axis_tvalid / s_axis_tready  | tuser: kind; tdata: event fields
//  m_axis  | out       | m_axis_tvalid / m_axis_tready  | tdata: status, plan, counters
//  cfg     | in        | cfg_we, no back-pressure       | cfg_wdata: retry_interval_ms
//
// Each event is held in the input register and evaluated there; when it fires, its result
// is written to the result register and offered from there until it is taken. One event
// per cycle is sustained while m_axis_tready stays high; the only loop is the plan state
// and counter update. Reset (rst_n, asynchronous, active low) clears the plan, the counters
// and both valid flags, and sets the retry interval to 1000 ms. A stalled result holds the
// input register, which in turn drops s_axis_tready.
`include "acked_delivery_retry_tracker_assert.svh"

module acked_delivery_retry_tracker
(
    input  logic         clk,
    input  logic         rst_n,
    // Configuration: retry_interval_ms, written whenever cfg_we is high.
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    // Events.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] seq, [23:16] attempt_limit, [87:24] now_ms, [151:88] deadline,
    // [152] authorized, [159:153] zero.
    input  logic [159:0] s_axis_tdata,
    // [1:0] kind.
    input  logic [1:0]   s_axis_tuser,
    // Results.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [5:3] event_res, [8:6] plan_state, [16:9] attempts_made,
    // [48:17] count_starts, [80:49] count_sends, [112:81] count_retries,
    // [144:113] count_delivered, [176:145] count_expired, [208:177] count_cancelled,
    // [240:209] count_failed, [272:241] count_invalid, [279:273] zero.
    output logic [279:0] m_axis_tdata
);
    import adrt_pkg::*;

    logic          in_valid_reg;
    in_item_t      in_item_reg;
    logic          out_valid_reg;
    logic [279:0]  out_data_reg;
    logic [15:0]   interval_reg;

    logic          fire;
    in_item_t      in_item_next;
    plan_dec_t     dec;
    counter_bank_t cnt_next;
    logic          wait_bound_ok;
    logic [279:0]  out_data_next;

    // The held event is evaluated as soon as the result register is free or being emptied.
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    // The input register takes a new transaction when it is empty or its event fires now.
    assign s_axis_tready = !in_valid_reg || fire;

    always_comb
    begin
        in_item_next.kind          = item_kind_t'(s_axis_tuser);
        in_item_next.seq           = s_axis_tdata[15:0];
        in_item_next.attempt_limit = s_axis_tdata[23:16];
        in_item_next.now_ms        = s_axis_tdata[87:24];
        in_item_next.deadline      = s_axis_tdata[151:88];
        in_item_next.authorized    = s_axis_tdata[152];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= RETRY_RESET_MS;
        end
        else if (cfg_we)
        begin
            interval_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // The event payload itself needs no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= in_item_next;
        end
    end

    adrt_plan u_plan
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .item           (in_item_reg),
        .retry_interval (interval_reg),
        .dec            (dec),
        .wait_bound_ok  (wait_bound_ok)
    );

    adrt_counters u_counters
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .bump     (dec.bump),
        .cnt_next (cnt_next)
    );

    always_comb
    begin
        out_data_next          = '0;
        out_data_next[2:0]     = dec.status;
        out_data_next[5:3]     = dec.event_res;
        out_data_next[8:6]     = dec.plan_state;
        out_data_next[16:9]    = dec.attempts_made;
        out_data_next[48:17]   = cnt_next[CNT_STARTS];
        out_data_next[80:49]   = cnt_next[CNT_SENDS];
        out_data_next[112:81]  = cnt_next[CNT_RETRIES];
        out_data_next[144:113] = cnt_next[CNT_DELIVERED];
        out_data_next[176:145] = cnt_next[CNT_EXPIRED];
        out_data_next[208:177] = cnt_next[CNT_CANCELLED];
        out_data_next[240:209] = cnt_next[CNT_FAILED];
        out_data_next[272:241] = cnt_next[CNT_INVALID];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Every evaluated event leaves a result waiting in the next cycle.
    `ADRT_ASSERT_NEXT(a_fire_gives_result, fire, m_axis_tvalid)
    // An event never moves more than one counter.
    `ADRT_ASSERT_NOW(a_single_bump, fire, $onehot0(dec.bump))
    // While waiting for an acknowledgement the attempts never run past the held limit.
    `ADRT_ASSERT_NOW(a_attempt_bound, 1'b1, wait_bound_ok)
    // A held event that cannot fire must block the input side.
    `ADRT_ASSERT_NOW(a_hold_blocks_input, in_valid_reg && !fire, !s_axis_tready)

endmodule

// File: design/adrt_plan.sv
// Delivery plan state and the per-event decision logic.
// Depends on adrt_pkg.
module adrt_plan
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  adrt_pkg::in_item_t item,
    input  logic [15:0]        retry_interval,
    output adrt_pkg::plan_dec_t dec,
    output logic               wait_bound_ok
);
    import adrt_pkg::*;

    plan_phase_t phase_reg, phase_next;
    logic [15:0] active_seq_reg, active_seq_next;
    logic [7:0]  limit_held_reg, limit_held_next;
    logic [7:0]  attempt_count_reg, attempt_count_next;
    logic [63:0] expiry_time_reg, expiry_time_next;
    logic [63:0] due_time_reg, due_time_next;

    logic begin_bad;
    logic expired_now;

    assign begin_bad = (item.seq == 16'd0) || (item.attempt_limit == 8'd0)
                    || (item.attempt_limit > 8'(MAX_ATTEMPT_LIMIT))
                    || !(item.deadline > item.now_ms) || !item.authorized;
    assign expired_now = (item.now_ms >= expiry_time_reg);

    always_comb
    begin
        phase_next         = phase_reg;
        active_seq_next    = active_seq_reg;
        limit_held_next    = limit_held_reg;
        attempt_count_next = attempt_count_reg;
        expiry_time_next   = expiry_time_reg;
        due_time_next      = due_time_reg;
        dec.status         = ST_OK;
        dec.event_res      = EV_NONE;
        dec.bump           = '0;
        case (item.kind)
            KIND_BEGIN:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    dec.status = ST_STATE;
                end
                else if (begin_bad)
                begin
                    // A rejected begin wipes whatever plan was left behind.
                    phase_next              = PH_IDLE;
                    active_seq_next         = '0;
                    limit_held_next         = '0;
                    attempt_count_next      = '0;
                    expiry_time_next        = '0;
                    due_time_next           = '0;
                    dec.bump[CNT_INVALID]   = 1'b1;
                    dec.status              = item.authorized ? ST_ARG : ST_AUTH;
                end
                else
                begin
                    phase_next             = PH_WAIT;
                    active_seq_next        = item.seq;
                    limit_held_next        = item.attempt_limit;
                    attempt_count_next     = '0;
                    expiry_time_next       = item.deadline;
                    due_time_next          = item.now_ms;
                    dec.bump[CNT_STARTS]   = 1'b1;
                end
            end
            KIND_POLL:
            begin
                if (phase_reg != PH_WAIT)
                begin
                    dec.status = ST_STATE;
                end
                else if (expired_now)
                begin
                    phase_next            = PH_EXPIRED;
                    dec.bump[CNT_EXPIRED] = 1'b1;
                    dec.event_res         = EV_EXPIRED;
                end
                else if (item.now_ms < due_time_reg)
                begin
                    // Not yet due: nothing to report.
                end
                else if (attempt_count_reg >= limit_held_reg)
                begin
                    phase_next           = PH_FAILED;
                    dec.bump[CNT_FAILED] = 1'b1;
                    dec.event_res        = EV_FAILED;
                end
                else
                begin
                    attempt_count_next = attempt_count_reg + 8'd1;
                    due_time_next      = item.now_ms + 64'(retry_interval);
                    if (attempt_count_reg == 8'd0)
                    begin
                        dec.bump[CNT_SENDS] = 1'b1;
                        dec.event_res       = EV_SEND;
                    end
                    else
                    begin
                        dec.bump[CNT_RETRIES] = 1'b1;
                        dec.event_res         = EV_RETRY;
                    end
                end
            end
            KIND_ACK:
            begin
                if (item.seq == 16'd0)
                begin
                    dec.bump[CNT_INVALID] = 1'b1;
                    dec.status            = ST_ARG;
                end
                else if (phase_reg != PH_WAIT || item.seq != active_seq_reg)
                begin
                    dec.status = ST_STATE;
                end
                else if (expired_now)
                begin
                    phase_next            = PH_EXPIRED;
                    dec.bump[CNT_EXPIRED] = 1'b1;
                    dec.event_res         = EV_EXPIRED;
                    dec.status            = ST_EXPIRED;
                end
                else if (attempt_count_reg == 8'd0)
                begin
                    dec.status = ST_STATE;
                end
                else
                begin
                    phase_next              = PH_DELIVERED;
                    dec.bump[CNT_DELIVERED] = 1'b1;
                    dec.event_res           = EV_DELIVERED;
                end
            end
            KIND_CANCEL:
            begin
                if (phase_reg != PH_WAIT)
                begin
                    dec.status = ST_STATE;
                end
                else
                begin
                    phase_next              = PH_CANCELLED;
                    due_time_next           = '0;
                    dec.bump[CNT_CANCELLED] = 1'b1;
                    dec.event_res           = EV_CANCELLED;
                end
            end
            default:
            begin
                dec.status = ST_STATE;
            end
        endcase
        dec.plan_state    = phase_next;
        dec.attempts_made = attempt_count_next;
    end

    assign wait_bound_ok = (phase_reg != PH_WAIT) || (attempt_count_reg <= limit_held_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            active_seq_reg    <= '0;
            limit_held_reg    <= '0;
            attempt_count_reg <= '0;
            expiry_time_reg   <= '0;
            due_time_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            active_seq_reg    <= active_seq_next;
            limit_held_reg    <= limit_held_next;
            attempt_count_reg <= attempt_count_next;
            expiry_time_reg   <= expiry_time_next;
            due_time_reg      <= due_time_next;
        end
    end

endmodule

// File: design/adrt_counters.sv
// Bank of eight wrapping 32-bit event counters.
// Depends on adrt_pkg; the updated values are presented for the result register.
module adrt_counters
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [adrt_pkg::NUM_COUNTERS-1:0] bump,
    output adrt_pkg::counter_bank_t       cnt_next
);
    import adrt_pkg::*;

    counter_bank_t cnt_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            cnt_next[i] = cnt_reg[i] + 32'(bump[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (fire)
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: verif/tb_acked_delivery_retry_tracker.sv
`timescale 1ns / 100ps
// Self-checking testbench for acked_delivery_retry_tracker: directed and random event streams.
// Depends on adrt_pkg and the design sources; the expected results come from a local predictor.

module tb_acked_delivery_retry_tracker;

    import adrt_pkg::*;

    // The run is cut off at this many cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Number of input transactions after which the random part stops.
    localparam int unsigned EVENT_TARGET = 1800;

    // Everything the block reports for one event, in the order it appears on m_axis_tdata.
    typedef struct packed {
        status_code_t  status;
        event_code_t   ev;
        plan_phase_t   phase;
        logic [7:0]    attempts;
        counter_bank_t counts;
    } outcome_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [15:0]  cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [15:0] seq, [23:16] attempt_limit, [87:24] now_ms, [151:88] deadline,
    // [152] authorized, [159:153] zero.
    logic [159:0] s_axis_tdata = '0;
    // [1:0] kind.
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [2:0] status, [5:3] event_res, [8:6] plan_state, [16:9] attempts_made,
    // [272:17] eight 32-bit counters from count_starts up, [279:273] zero.
    logic [279:0] m_axis_tdata;

    acked_delivery_retry_tracker dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Predictor state: our own copy of the plan, the counters and the retry interval.
    // ------------------------------------------------------------------------------------
    plan_phase_t   plan_ph    = PH_IDLE;
    logic [15:0]   plan_seq   = '0;
    logic [7:0]    plan_limit = '0;
    logic [7:0]    plan_tries = '0;
    logic [63:0]   plan_expiry = '0;
    logic [63:0]   plan_due   = '0;
    counter_bank_t tally      = '0;
    logic [15:0]   retry_ms   = RETRY_RESET_MS;

    // Results predicted for accepted events and not yet seen on the output, oldest first.
    outcome_t pending_results[$];

    int unsigned accepted_events = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;

    // Knobs for the two sides. Random idling is switched per phase; a non-zero hold makes
    // the receiver refuse results for that many cycles.
    bit          src_jitter  = 1'b0;
    bit          sink_jitter = 1'b0;
    int unsigned sink_hold   = 0;

    string cnt_name[NUM_COUNTERS] = '{"count_starts", "count_sends", "count_retries",
                                      "count_delivered", "count_expired", "count_cancelled",
                                      "count_failed", "count_invalid"};

    function automatic void wipe_plan();
        plan_ph     = PH_IDLE;
        plan_seq    = '0;
        plan_limit  = '0;
        plan_tries  = '0;
        plan_expiry = '0;
        plan_due    = '0;
    endfunction

    // Advances the predicted plan by one event and returns what the block must report.
    function automatic outcome_t predict_outcome(input in_item_t it);
        outcome_t     res;
        status_code_t st;
        event_code_t  ev;
        st = ST_OK;
        ev = EV_NONE;
        case (it.kind)
            KIND_BEGIN:
            begin
                if (plan_ph == PH_WAIT)
                begin
                    st = ST_STATE;
                end
                else if (it.seq == 16'd0 || it.attempt_limit < 8'd1
                         || it.attempt_limit > 8'(MAX_ATTEMPT_LIMIT)
                         || !(it.deadline > it.now_ms) || !it.authorized)
                begin
                    // A rejected begin wipes the old plan, whatever state it was in.
                    wipe_plan();
                    tally[CNT_INVALID] = tally[CNT_INVALID] + 32'd1;
                    st = it.authorized ? ST_ARG : ST_AUTH;
                end
                else
                begin
                    plan_seq    = it.seq;
                    plan_limit  = it.attempt_limit;
                    plan_tries  = '0;
                    plan_expiry = it.deadline;
                    plan_due    = it.now_ms;
                    plan_ph     = PH_WAIT;
                    tally[CNT_STARTS] = tally[CNT_STARTS] + 32'd1;
                end
            end
            KIND_POLL:
            begin
                if (plan_ph != PH_WAIT)
                begin
                    st = ST_STATE;
                end
                else if (it.now_ms >= plan_expiry)
                begin
                    plan_ph = PH_EXPIRED;
                    tally[CNT_EXPIRED] = tally[CNT_EXPIRED] + 32'd1;
                    ev = EV_EXPIRED;
                end
                else if (it.now_ms < plan_due)
                begin
                    ev = EV_NONE;
                end
                else if (plan_tries >= plan_limit)
                begin
                    plan_ph = PH_FAILED;
                    tally[CNT_FAILED] = tally[CNT_FAILED] + 32'd1;
                    ev = EV_FAILED;
                end
                else
                begin
                    // The next due time wraps modulo 2^64 near the top of the time range.
                    plan_tries = plan_tries + 8'd1;
                    plan_due   = it.now_ms + {48'd0, retry_ms};
                    if (plan_tries == 8'd1)
                    begin
                        tally[CNT_SENDS] = tally[CNT_SENDS] + 32'd1;
                        ev = EV_SEND;
                    end
                    else
                    begin
                        tally[CNT_RETRIES] = tally[CNT_RETRIES] + 32'd1;
                        ev = EV_RETRY;
                    end
                end
            end
            KIND_ACK:
            begin
                // A zero sequence is refused before the phase is even looked at.
                if (it.seq == 16'd0)
                begin
                    tally[CNT_INVALID] = tally[CNT_INVALID] + 32'd1;
                    st = ST_ARG;
                end
                else if (plan_ph != PH_WAIT || it.seq != plan_seq)
                begin
                    st = ST_STATE;
                end
                else if (it.now_ms >= plan_expiry)
                begin
                    plan_ph = PH_EXPIRED;
                    tally[CNT_EXPIRED] = tally[CNT_EXPIRED] + 32'd1;
                    ev = EV_EXPIRED;
                    st = ST_EXPIRED;
                end
                else if (plan_tries == 8'd0)
                begin
                    st = ST_STATE;
                end
                else
                begin
                    plan_ph = PH_DELIVERED;
                    tally[CNT_DELIVERED] = tally[CNT_DELIVERED] + 32'd1;
                    ev = EV_DELIVERED;
                end
            end
            default:
            begin
                if (plan_ph != PH_WAIT)
                begin
                    st = ST_STATE;
                end
                else
                begin
                    plan_ph  = PH_CANCELLED;
                    plan_due = '0;
                    tally[CNT_CANCELLED] = tally[CNT_CANCELLED] + 32'd1;
                    ev = EV_CANCELLED;
                end
            end
        endcase
        res.status   = st;
        res.ev       = ev;
        res.phase    = plan_ph;
        res.attempts = plan_tries;
        res.counts   = tally;
        return res;
    endfunction

    function automatic in_item_t make_event(input item_kind_t kind, input logic [15:0] seq,
                                            input logic [7:0] lim, input logic [63:0] now,
                                            input logic [63:0] dl, input logic auth);
        in_item_t it;
        it.kind          = kind;
        it.seq           = seq;
        it.attempt_limit = lim;
        it.now_ms        = now;
        it.deadline      = dl;
        it.authorized    = auth;
        return it;
    endfunction

    // Any kind with every field drawn over its full width.
    function automatic in_item_t random_event();
        return make_event(item_kind_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                          {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom));
    endfunction

    // ------------------------------------------------------------------------------------
    // Sender. Called at a rising edge; returns at the edge where the transaction was taken,
    // with tvalid still high so that back-to-back events need no dead cycle.
    // ------------------------------------------------------------------------------------
    task automatic send_event(input in_item_t it);
        if (src_jitter && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {7'd0, it.authorized, it.deadline, it.now_ms, it.attempt_limit,
                          it.seq};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_outcome(it));
        accepted_events++;
    endtask

    // Stops offering events and waits until every predicted result has been seen.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Every event yields a result, so once the store is empty the block is idle.
    task automatic write_interval(input logic [15:0] ms);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= ms;
        @(posedge clk);
        cfg_we    <= 1'b0;
        retry_ms = ms;
    endtask

    // ------------------------------------------------------------------------------------
    // Receiver: random refusals in short bursts, or one long hold when asked for.
    // ------------------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_hold != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
                m_axis_tready <= 1'b1;
            end
            else if (sink_jitter && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Result checking, field by field against the oldest prediction.
    // ------------------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s after %0d events: expected %0h, got %0h",
                         name, accepted_events, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: %0h", m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", m_axis_tdata[2:0], want.status);
                check_field("event_res", m_axis_tdata[5:3], want.ev);
                check_field("plan_state", m_axis_tdata[8:6], want.phase);
                check_field("attempts_made", m_axis_tdata[16:9], want.attempts);
                for (int i = 0; i < NUM_COUNTERS; i++)
                    check_field(cnt_name[i], m_axis_tdata[17 + 32 * i +: 32],
                                want.counts[i]);
                check_field("padding", m_axis_tdata[279:273], 32'd0);
            end
        end
    end

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------------------------

    // One plan from begin to (usually) its end: a valid begin at a random time, then mostly
    // polls with time moving forward by up to two retry intervals, mixed with acks, the odd
    // cancel, a second begin and stray noise. A few begins are spoilt on purpose.
    task automatic run_plan();
        logic [63:0] t;
        logic [63:0] step_max;
        logic [63:0] dl;
        logic [15:0] id;
        logic [7:0]  lim;
        logic        auth;
        int          steps;
        int          pick;
        t = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                        : 64'($urandom_range(0, 1000000));
        id       = 16'($urandom_range(1, 65535));
        lim      = 8'($urandom_range(1, MAX_ATTEMPT_LIMIT));
        auth     = 1'b1;
        step_max = (retry_ms == 16'd0) ? 64'd4 : 64'd2 * retry_ms;
        dl = t + 64'($urandom_range(1, 32'(step_max)))
               + step_max * 64'($urandom_range(0, lim));
        if ($urandom_range(0, 9) == 0)
            send_event(random_event());
        case ($urandom_range(0, 19))
            0: id = '0;
            1: lim = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(9, 255));
            2: dl = t - 64'($urandom_range(0, 5));
            3: auth = 1'b0;
            default: ;
        endcase
        send_event(make_event(KIND_BEGIN, id, lim, t, dl, auth));
        steps = $urandom_range(1, 14);
        for (int n = 0; n < steps; n++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
            begin
                t = t + 64'($urandom_range(0, 32'(step_max)));
                send_event(make_event(KIND_POLL, 16'($urandom), 8'($urandom), t,
                                      {$urandom, $urandom}, 1'($urandom)));
            end
            else if (pick < 17)
            begin
                t = t + 64'($urandom_range(0, 32'(step_max / 4)));
                send_event(make_event(KIND_ACK,
                                      ($urandom_range(0, 4) != 0) ? id : 16'($urandom),
                                      8'($urandom), t, {$urandom, $urandom}, 1'($urandom)));
            end
            else if (pick == 17)
            begin
                send_event(make_event(KIND_CANCEL, 16'($urandom), 8'($urandom), t,
                                      {$urandom, $urandom}, 1'($urandom)));
            end
            else if (pick == 18)
            begin
                send_event(make_event(KIND_BEGIN, 16'($urandom_range(1, 65535)), lim, t,
                                      t + step_max, 1'b1));
            end
            else
            begin
                send_event(random_event());
            end
            if (plan_ph != PH_WAIT && $urandom_range(0, 2) != 0)
                break;
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------------------

    // Poll, zero-sequence ack and cancel straight after reset, with no plan armed.
    task automatic test_idle_rejects();
        send_event(make_event(KIND_POLL, 16'd7, 8'd1, 64'd0, 64'd0, 1'b1));
        send_event(make_event(KIND_ACK, 16'd0, 8'd0, 64'd5, 64'd0, 1'b0));
        send_event(make_event(KIND_CANCEL, 16'd9, 8'd3, 64'd5, 64'd9, 1'b1));
    endtask

    // Each begin check failing on its own, and authority loss reported over a bad limit.
    task automatic test_begin_checks();
        send_event(make_event(KIND_BEGIN, 16'd0, 8'd4, 64'd0, 64'd100, 1'b1));
        send_event(make_event(KIND_BEGIN, 16'd5, 8'd0, 64'd0, 64'd100, 1'b1));
        send_event(make_event(KIND_BEGIN, 16'd5, 8'd9, 64'd0, 64'd100, 1'b1));
        send_event(make_event(KIND_BEGIN, 16'd5, 8'd4, 64'd100, 64'd100, 1'b1));
        send_event(make_event(KIND_BEGIN, 16'd5, 8'd255, 64'd0, 64'd100, 1'b0));
    endtask

    // A full plan at the reset interval of 1000 ms: first send, a poll one millisecond
    // early, the retry, a begin and two acks that must be refused, then delivery.
    task automatic test_send_and_retry();
        send_event(make_event(KIND_BEGIN, 16'hFFFF, 8'd8, 64'd0, '1, 1'b1));
        send_event(make_event(KIND_BEGIN, 16'd3, 8'd2, 64'd0, 64'd50, 1'b1));
        send_event(make_event(KIND_ACK, 16'hFFFF, 8'd0, 64'd0, 64'd0, 1'b0));
        send_event(make_event(KIND_POLL, 16'd0, 8'd0, 64'd0, 64'd0, 1'b0));
        send_event(make_event(KIND_POLL, 16'd0, 8'd0, 64'd999, 64'd0, 1'b0));
        send_event(make_event(KIND_POLL, 16'd0, 8'd0, 64'd1000, 64'd0, 1'b0));
        send_event(make_event(KIND_ACK, 16'd1234, 8'd0, 64'd1001, 64'd0, 1'b0));
        send_event(make_event(KIND_ACK, 16'hFFFF, 8'd0, 64'd1001, 64'd0, 1'b0));
    endtask

    // Failure after a single attempt, expiry on a poll at the deadline, a due time that
    // wraps past 2^64 with an ack arriving exactly at the deadline, and a cancel.
    task automatic test_terminal_outcomes();
        send_event(make_event(KIND_BEGIN, 16'd1, 8'd1, 64'd0, 64'd1000000, 1'b1));
        send_event(make_event(KIND_POLL, 16'd0, 8'd0, 64'd0, 64'd0, 1'b0));
        send_event(make_event(KIND_POLL, 16'd0, 8'd0, 64'd1000, 64'd0, 1'b0));
        send_event(make_event(KIND_BEGIN, 16'd2, 8'd8, 64'd10, 64'd20, 1'b1));
        send_event(make_event(KIND_POLL, 16'd0, 8'd0, 64'd20, 64'd0, 1'b0));
        send_event(make_event(KIND_BEGIN, 16'h8000, 8'd2, 64'hFFFF_FFFF_FFFF_FFFE, '1, 1'b1));
        send_event(make_event(KIND_POLL, 16'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 1'b0));
        send_event(make_event(KIND_POLL, 16'd0, 8'd0, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 1'b0));
        send_event(make_event(KIND_ACK, 16'h8000, 8'd0, '1, 64'd0, 1'b0));
        send_event(make_event(KIND_BEGIN, 16'd3, 8'd3, 64'd5, 64'd6, 1'b1));
        send_event(make_event(KIND_CANCEL, 16'd0, 8'd0, 64'd5, 64'd0, 1'b0));
    endtask

    // A zero interval makes every retry due at once; then the largest interval and the smallest non-zero one.
    task automatic test_interval_settings();
        write_interval(16'd0);
        send_event(make_event(KIND_BEGIN, 16'd4, 8'd3, 64'd100, 64'd200, 1'b1));
        repeat (4) send_event(make_event(KIND_POLL, 16'd0, 8'd0, 64'd100, 64'd0, 1'b0));
        write_interval(16'hFFFF);
        repeat (3) run_plan();
        write_interval(16'd1);
        repeat (3) run_plan();
    endtask

    // The receiver stops for a long stretch while events keep coming, so the block fills
    // up and has to hold off its input.
    task automatic test_backpressure();
        drain_results();
        src_jitter = 1'b0;
        sink_hold  = 300;
        repeat (4) run_plan();
    endtask

    // Random phases, each with its own interval and idling pattern. The last stretch runs
    // with no idling on either side.
    task automatic test_random_plans();
        logic [15:0] ms;
        while (accepted_events < EVENT_TARGET - 150)
        begin
            case ($urandom_range(0, 5))
                0: ms = 16'd1;
                1: ms = 16'hFFFF;
                2: ms = 16'($urandom_range(1, 50));
                3: ms = RETRY_RESET_MS;
                default: ms = 16'($urandom_range(1, 65535));
            endcase
            write_interval(ms);
            src_jitter  = ($urandom_range(0, 3) != 0);
            sink_jitter = ($urandom_range(0, 3) != 0);
            repeat (8) run_plan();
        end
        write_interval(16'($urandom_range(1, 2000)));
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        while (accepted_events < EVENT_TARGET)
            run_plan();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
        test_idle_rejects();
        test_begin_checks();
        test_send_and_retry();
        test_terminal_outcomes();
        test_interval_settings();
        test_backpressure();
        test_random_plans();
        drain_results();
        // Any stray result arriving after the drain is caught here.
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
